// ----- src/qbps_pkg.sv -----
// ----------------------------------------------------------------------------
// qbps_pkg: shared constants for the quadratic curve point sampler
// Default parameters, register indexes and queue sizes.
// ----------------------------------------------------------------------------
`default_nettype none
package qbps_pkg;

	localparam int DEF_MAX_POINTS = 64;
	localparam int DEF_COORD_BITS = 12;

	localparam int IN_W     = 12;
	localparam int SLICE_W  = 16;
	localparam int SPACE_W  = 16;
	localparam int POINT_W  = 20;
	localparam int STEP_W   = 17;
	localparam int WIDX_W   = 8;

	localparam logic [SPACE_W-1:0] SPACING_RESET = 16'd256;
	localparam logic [STEP_W-1:0]  ONE_Q16       = 17'h10000;

	// Descriptor queue between front and back, result queue at the output
	localparam int DQ_DEPTH = 2;
	localparam int OQ_DEPTH = 8;
	// Stages between sample issue and result queue write
	localparam int BACK_STAGES = 3;

	typedef enum logic [WIDX_W-1:0] {
		REG_SPACING = 8'd0,
		REG_SLICE   = 8'd1
	} reg_idx_t;

endpackage
`default_nettype wire

// ----- src/qbps_fifo.sv -----
// ----------------------------------------------------------------------------
// qbps_fifo: small synchronous queue
// Register-array queue with occupancy count; head is shown while not empty.
// ----------------------------------------------------------------------------
`default_nettype none
module qbps_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr,
	input  wire logic [W-1:0]               wdata,
	input  wire logic                       rd,
	output logic [W-1:0]                    rdata,
	output logic                            full,
	output logic                            empty,
	output logic [$clog2(DEPTH+1)-1:0]      count
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [W-1:0]  mem [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign count = cnt_q;
	assign rdata = mem[rp_q];

	// Store the incoming item
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wp_q] <= wdata;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + AW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + AW'(1);
			end
			cnt_q <= cnt_q + CW'(do_wr) - CW'(do_rd);
		end
	end
endmodule
`default_nettype wire

// ----- src/qbps_front.sv -----
// ----------------------------------------------------------------------------
// qbps_front: curve intake and sample count
// Measures the control polygon with a shared square/root unit, divides by
// the spacing and computes the Q1.16 step with one shared restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
module qbps_front #(
	parameter int COORD_BITS = 12,
	parameter int MAX_POINTS = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              take,
	input  wire logic [qbps_pkg::IN_W-1:0]         in_pt [6],
	input  wire logic [qbps_pkg::SPACE_W-1:0]      spacing,
	output logic                                   busy,
	output logic                                   desc_push,
	output logic [6*COORD_BITS+$clog2(MAX_POINTS+1)+qbps_pkg::STEP_W-1:0] desc_data,
	input  wire logic                              desc_full
);
	import qbps_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int NW = $clog2(MAX_POINTS+1);
	localparam int RB = C + 9;          // root bits
	localparam int RW = 2 * RB;         // radicand bits
	localparam int DW = C + 10;         // polygon length / quotient bits
	localparam int CW = $clog2(DW+1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SQ   = 6'b000010,
		ST_ROOT = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_STEP = 6'b010000,
		ST_PUSH = 6'b100000
	} fstate_t;

	fstate_t              state_q;
	logic [C-1:0]         pts_q [6];
	logic                 seg_q, ph_q;
	logic [2*C:0]         acc_q;
	logic [RW-1:0]        rad_q;
	logic [RB+1:0]        rem_q;
	logic [RB-1:0]        root_q;
	logic [DW-1:0]        total_q;
	logic [DW-1:0]        dvd_q;
	logic [SPACE_W:0]     drem_q;
	logic [CW-1:0]        cnt_q;
	logic [NW-1:0]        n_q;
	logic [STEP_W-1:0]    step_q;

	logic [2:0]           hi_i, lo_i;
	logic [C-1:0]         absd;
	logic [2*C-1:0]       sqv;
	logic [2*C:0]         sqsum;
	logic [RB+1:0]        r2, trial;
	logic                 rge;
	logic [RB+1:0]        rem_n;
	logic [RB-1:0]        root_n;
	logic [DW-1:0]        total_n;
	logic [SPACE_W-1:0]   dvsr;
	logic [SPACE_W:0]     d2;
	logic                 dge;
	logic [DW-1:0]        quo_n;
	logic [NW-1:0]        nsat;

	// Pick the coordinate pair of the current segment and axis
	assign hi_i = 3'(2 + 2 * int'(seg_q) + int'(ph_q));
	assign lo_i = 3'(2 * int'(seg_q) + int'(ph_q));
	assign absd = (pts_q[hi_i] >= pts_q[lo_i]) ? pts_q[hi_i] - pts_q[lo_i]
	                                           : pts_q[lo_i] - pts_q[hi_i];
	assign sqv   = absd * absd;
	assign sqsum = acc_q + (2*C+1)'(sqv);

	// One digit of the square root
	assign r2      = {rem_q[RB-1:0], rad_q[RW-1:RW-2]};
	assign trial   = {root_q, 2'b01};
	assign rge     = (r2 >= trial);
	assign rem_n   = rge ? r2 - trial : r2;
	assign root_n  = {root_q[RB-2:0], rge};
	assign total_n = total_q + DW'(root_n);

	// One bit of the shared divider
	assign dvsr  = (state_q == ST_STEP) ? SPACE_W'(n_q) : spacing;
	assign d2    = {drem_q[SPACE_W-1:0], dvd_q[DW-1]};
	assign dge   = (d2 >= {1'b0, dvsr});
	assign quo_n = {dvd_q[DW-2:0], dge};
	assign nsat  = (quo_n > DW'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(quo_n);

	assign busy      = (state_q != ST_IDLE);
	assign desc_push = (state_q == ST_PUSH) && !desc_full;
	assign desc_data = {pts_q[0], pts_q[1], pts_q[2], pts_q[3], pts_q[4], pts_q[5],
	                    n_q, step_q};

	// Hold the control points of the accepted curve
	always_ff @(posedge clk) begin
		if (take && !busy) begin
			for (int k = 0; k < 6; k++) begin
				pts_q[k] <= C'(in_pt[k]);
			end
		end
	end

	// Sequence squares, roots and divisions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seg_q   <= 1'b0;
			ph_q    <= 1'b0;
			cnt_q   <= '0;
			acc_q   <= '0;
			rad_q   <= '0;
			rem_q   <= '0;
			root_q  <= '0;
			total_q <= '0;
			dvd_q   <= '0;
			drem_q  <= '0;
			n_q     <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						seg_q   <= 1'b0;
						ph_q    <= 1'b0;
						total_q <= '0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (!ph_q) begin
						acc_q <= (2*C+1)'(sqv);
						ph_q  <= 1'b1;
					end else begin
						rad_q   <= RW'({sqsum, 16'b0});
						rem_q   <= '0;
						root_q  <= '0;
						cnt_q   <= '0;
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					rem_q  <= rem_n;
					root_q <= root_n;
					rad_q  <= {rad_q[RW-3:0], 2'b00};
					cnt_q  <= cnt_q + CW'(1);
					if (cnt_q == CW'(RB-1)) begin
						total_q <= total_n;
						cnt_q   <= '0;
						drem_q  <= '0;
						if (!seg_q) begin
							seg_q   <= 1'b1;
							ph_q    <= 1'b0;
							state_q <= ST_SQ;
						end else if (spacing == '0) begin
							n_q     <= NW'(MAX_POINTS);
							dvd_q   <= DW'(ONE_Q16);
							state_q <= ST_STEP;
						end else begin
							dvd_q   <= total_n;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					drem_q <= dge ? d2 - {1'b0, dvsr} : d2;
					dvd_q  <= quo_n;
					cnt_q  <= cnt_q + CW'(1);
					if (cnt_q == CW'(DW-1)) begin
						cnt_q  <= '0;
						drem_q <= '0;
						n_q    <= nsat;
						dvd_q  <= DW'(ONE_Q16);
						// Drop a curve that yields no sample
						state_q <= (nsat == '0) ? ST_IDLE : ST_STEP;
					end
				end
				ST_STEP: begin
					drem_q <= dge ? d2 - {1'b0, dvsr} : d2;
					dvd_q  <= quo_n;
					cnt_q  <= cnt_q + CW'(1);
					if (cnt_q == CW'(DW-1)) begin
						cnt_q   <= '0;
						step_q  <= STEP_W'(quo_n);
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!desc_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- src/qbps_back.sv -----
// ----------------------------------------------------------------------------
// qbps_back: sample generator
// Walks the samples of one curve descriptor and evaluates the two-level
// lerp in a three-stage pipeline, one sample per cycle while the queue has room.
// ----------------------------------------------------------------------------
`default_nettype none
module qbps_back #(
	parameter int COORD_BITS = 12,
	parameter int MAX_POINTS = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [6*COORD_BITS+$clog2(MAX_POINTS+1)+qbps_pkg::STEP_W-1:0] desc_data,
	input  wire logic                              desc_empty,
	output logic                                   desc_pop,
	input  wire logic [$clog2(qbps_pkg::OQ_DEPTH+1)-1:0] res_count,
	output logic                                   res_push,
	output logic [2*qbps_pkg::POINT_W:0]           res_data
);
	import qbps_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int NW = $clog2(MAX_POINTS+1);
	localparam int OW = $clog2(OQ_DEPTH+1);
	localparam int LW = C + 20;

	// Returns (p << 16) + (q - p) * t, nonnegative for t <= 1.0
	function automatic logic signed [LW-1:0] lerp_raw(input logic [C-1:0] p,
		input logic [C-1:0] q, input logic [STEP_W-1:0] t);
		logic signed [C:0]    d;
		logic signed [C+18:0] m;
		d = $signed({1'b0, q}) - $signed({1'b0, p});
		m = d * $signed({1'b0, t});
		return $signed({4'b0000, p, 16'b0}) + LW'(m);
	endfunction

	logic [C-1:0]      d_pt [6];
	logic [NW-1:0]     d_n;
	logic [STEP_W-1:0] d_step;
	logic [NW-1:0]     idx_q;
	logic              issue, is_last;

	logic              v_s1, v_s2, v_s3;
	logic              last_s1, last_s2, last_s3;
	logic [STEP_W-1:0] t_s1, t_s2;
	logic [C-1:0]      pt_s1 [6];
	logic [C-1:0]      xa_s2, ya_s2, xb_s2, yb_s2;
	logic [POINT_W-1:0] col_s3, row_s3;
	logic signed [LW-1:0] xa_w, ya_w, xb_w, yb_w, col_w, row_w;

	assign {d_pt[0], d_pt[1], d_pt[2], d_pt[3], d_pt[4], d_pt[5], d_n, d_step} = desc_data;

	// Issue only with room for every sample still in the pipeline
	assign issue    = !desc_empty && (res_count < OW'(OQ_DEPTH - BACK_STAGES));
	assign is_last  = (idx_q == d_n - NW'(1));
	assign desc_pop = issue && is_last;

	assign xa_w  = lerp_raw(pt_s1[0], pt_s1[2], t_s1);
	assign ya_w  = lerp_raw(pt_s1[1], pt_s1[3], t_s1);
	assign xb_w  = lerp_raw(pt_s1[2], pt_s1[4], t_s1);
	assign yb_w  = lerp_raw(pt_s1[3], pt_s1[5], t_s1);
	assign col_w = lerp_raw(xa_s2, xb_s2, t_s2);
	assign row_w = lerp_raw(ya_s2, yb_s2, t_s2);

	assign res_push = v_s3;
	assign res_data = {col_s3, row_s3, last_s3};

	// Advance the sample index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
		end else begin
			if (issue) begin
				idx_q <= is_last ? '0 : idx_q + NW'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Evaluate t, first-level lerps, then the point
	always_ff @(posedge clk) begin
		t_s1    <= STEP_W'(idx_q * d_step);
		pt_s1   <= d_pt;
		last_s1 <= is_last;

		xa_s2   <= xa_w[C+15:16];
		ya_s2   <= ya_w[C+15:16];
		xb_s2   <= xb_w[C+15:16];
		yb_s2   <= yb_w[C+15:16];
		t_s2    <= t_s1;
		last_s2 <= last_s1;

		col_s3  <= POINT_W'(col_w[C+15:8]);
		row_s3  <= POINT_W'(row_w[C+15:8]);
		last_s3 <= last_s2;
	end

	// Sample index stays inside the current curve
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		!desc_empty |-> (idx_q < d_n))
		else $error("sample index beyond sample count");

	// The last sample of a curve also releases its descriptor
	a_last_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && is_last) |-> desc_pop)
		else $error("last sample without descriptor release");

	// A result reaches the result queue after stages s1, s2 and s3 following its issue
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> ##2 res_push)
		else $error("issued sample did not reach the result queue");
endmodule
`default_nettype wire

// ----- src/quadratic_bezier_point_sampler.sv -----
// Each curve passes squares and a bit-serial square root per segment in the front, then two
// restoring divisions (sample count, then step); a zero spacing skips the count division.
// The first point then passes the descriptor queue and the back pipeline.
// The front is busy (full high) for that whole measurement.
// Throughput: one point per cycle while results are popped; a new curve is measured
// while the previous one still emits its points. Reset is asynchronous, active low,
// clears queues and control state and loads sample_spacing=256, slice_number=0.
// ----------------------------------------------------------------------------
// quadratic_bezier_point_sampler: quadratic curve point sampler
// Front measures each curve, a descriptor queue decouples it from the sample
// generator, and a result queue holds the emitted points.
// ----------------------------------------------------------------------------
`default_nettype none
module quadratic_bezier_point_sampler #(
	parameter int MAX_POINTS = qbps_pkg::DEF_MAX_POINTS,
	parameter int COORD_BITS = qbps_pkg::DEF_COORD_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [qbps_pkg::IN_W-1:0]     start_x,
	input  wire logic [qbps_pkg::IN_W-1:0]     start_y,
	input  wire logic [qbps_pkg::IN_W-1:0]     mid_x,
	input  wire logic [qbps_pkg::IN_W-1:0]     mid_y,
	input  wire logic [qbps_pkg::IN_W-1:0]     end_x,
	input  wire logic [qbps_pkg::IN_W-1:0]     end_y,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [qbps_pkg::SLICE_W-1:0]       point_slice,
	output logic [qbps_pkg::POINT_W-1:0]       point_col,
	output logic [qbps_pkg::POINT_W-1:0]       point_row,
	output logic                               last_point,
	input  wire logic                          wr_en,
	input  wire logic [qbps_pkg::WIDX_W-1:0]   wr_index,
	input  wire logic [qbps_pkg::SPACE_W-1:0]  wr_data
);
	import qbps_pkg::*;

	localparam int NW  = $clog2(MAX_POINTS+1);
	localparam int DSW = 6*COORD_BITS + NW + STEP_W;
	localparam int RSW = 2*POINT_W + 1;
	localparam int OW  = $clog2(OQ_DEPTH+1);

	logic [SPACE_W-1:0] spacing_q;
	logic [SLICE_W-1:0] slice_q;
	logic [IN_W-1:0]    in_pt [6];
	logic               busy;
	logic               desc_push, desc_pop, desc_full, desc_empty;
	logic [DSW-1:0]     desc_wdata, desc_rdata;
	logic [$clog2(DQ_DEPTH+1)-1:0] desc_count;
	logic               res_push, res_full;
	logic [RSW-1:0]     res_wdata, res_rdata;
	logic [OW-1:0]      res_count;

	assign in_pt[0] = start_x;
	assign in_pt[1] = start_y;
	assign in_pt[2] = mid_x;
	assign in_pt[3] = mid_y;
	assign in_pt[4] = end_x;
	assign in_pt[5] = end_y;
	assign full     = busy;

	// Write configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= SPACING_RESET;
			slice_q   <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SPACING: spacing_q <= wr_data;
				REG_SLICE:   slice_q   <= wr_data;
				default: ;
			endcase
		end
	end

	qbps_front #(.COORD_BITS(COORD_BITS), .MAX_POINTS(MAX_POINTS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (push),
		.in_pt     (in_pt),
		.spacing   (spacing_q),
		.busy      (busy),
		.desc_push (desc_push),
		.desc_data (desc_wdata),
		.desc_full (desc_full)
	);

	qbps_fifo #(.W(DSW), .DEPTH(DQ_DEPTH)) u_desc_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (desc_push),
		.wdata  (desc_wdata),
		.rd     (desc_pop),
		.rdata  (desc_rdata),
		.full   (desc_full),
		.empty  (desc_empty),
		.count  (desc_count)
	);

	qbps_back #(.COORD_BITS(COORD_BITS), .MAX_POINTS(MAX_POINTS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_data  (desc_rdata),
		.desc_empty (desc_empty),
		.desc_pop   (desc_pop),
		.res_count  (res_count),
		.res_push   (res_push),
		.res_data   (res_wdata)
	);

	qbps_fifo #(.W(RSW), .DEPTH(OQ_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.wdata  (res_wdata),
		.rd     (pop),
		.rdata  (res_rdata),
		.full   (res_full),
		.empty  (empty),
		.count  (res_count)
	);

	assign point_slice = slice_q;
	assign {point_col, point_row, last_point} = res_rdata;

	// Descriptor queue never overflows
	a_desc_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		!(desc_push && desc_full) && (desc_count <= 2'(DQ_DEPTH)))
		else $error("descriptor queue overflow");

	// Result queue never takes a point it cannot hold
	a_res_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_push && res_full))
		else $error("result queue overflow");

	// An accepted curve keeps the front busy on the next cycle
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> full)
		else $error("front did not start on accepted curve");
endmodule
`default_nettype wire
